@@ rtl/nf4_pkg.sv @@
// NF4 dequantizing GEMV package: state codes, lane control struct, NF4 table
// and the fp16/fp32 unpack, multiply, add and round/pack functions.
// No dependencies.
package nf4_pkg;

	localparam int COLUMNS = 8;
	localparam int COL_W   = 3;

	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FIN  = 2'd1;
	localparam logic [1:0] CLS_INF  = 2'd2;
	localparam logic [1:0] CLS_NAN  = 2'd3;

	localparam logic signed [7:0] CODE_LEVELS [16] = '{
		-8'sd127, -8'sd88, -8'sd67, -8'sd50, -8'sd36, -8'sd23, -8'sd12, 8'sd0,
		8'sd10, 8'sd20, 8'sd31, 8'sd43, 8'sd56, 8'sd71, 8'sd92, 8'sd127
	};

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_ACT  = 14'b00000000000010,
		S_W    = 14'b00000000000100,
		S_MUL  = 14'b00000000001000,
		S_ADD  = 14'b00000000010000,
		S_WB   = 14'b00000000100000,
		S_F1   = 14'b00000001000000,
		S_F2   = 14'b00000010000000,
		S_F3   = 14'b00000100000000,
		S_F4   = 14'b00001000000000,
		S_F5   = 14'b00010000000000,
		S_F6   = 14'b00100000000000,
		S_F7   = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} nf4_state_t;

	typedef struct packed {
		nf4_state_t st;
		logic [1:0] slot;
		logic       clr_run;
	} lane_ctl_t;

	// unpacked value: mag * 2^exp
	typedef struct packed {
		logic [1:0]        cls;
		logic              neg;
		logic [27:0]       mag;
		logic signed [9:0] exp;
	} xval_t;

	function automatic int msb28(logic [27:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) p = i;
		end
		return p;
	endfunction

	function automatic xval_t dec16(logic [15:0] b);
		xval_t x;
		x.neg = b[15];
		x.mag = '0;
		x.exp = '0;
		if (b[14:10] == 5'h1f) begin
			x.cls = (b[9:0] != 10'd0) ? CLS_NAN : CLS_INF;
		end else if (b[14:10] == 5'd0) begin
			x.cls = (b[9:0] != 10'd0) ? CLS_FIN : CLS_ZERO;
			x.mag = {18'd0, b[9:0]};
			x.exp = -10'sd24;
		end else begin
			x.cls = CLS_FIN;
			x.mag = {17'd0, 1'b1, b[9:0]};
			x.exp = 10'(-25 + int'(b[14:10]));
		end
		return x;
	endfunction

	function automatic xval_t dec32(logic [31:0] b);
		xval_t x;
		x.neg = b[31];
		x.mag = '0;
		x.exp = '0;
		if (b[30:23] == 8'hff) begin
			x.cls = (b[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
		end else if (b[30:23] == 8'd0) begin
			x.cls = (b[22:0] != 23'd0) ? CLS_FIN : CLS_ZERO;
			x.mag = {5'd0, b[22:0]};
			x.exp = -10'sd149;
		end else begin
			x.cls = CLS_FIN;
			x.mag = {4'd0, 1'b1, b[22:0]};
			x.exp = 10'(-150 + int'(b[30:23]));
		end
		return x;
	endfunction

	function automatic xval_t tab_val(logic [3:0] code);
		xval_t x;
		logic signed [7:0] v;
		logic [7:0] a;
		v = CODE_LEVELS[code];
		a = v[7] ? 8'(-v) : 8'(v);
		x.cls = (v == 8'sd0) ? CLS_ZERO : CLS_FIN;
		x.neg = v[7];
		x.mag = {20'd0, a};
		x.exp = '0;
		return x;
	endfunction

	// operands carry at most 11 significant bits
	function automatic xval_t mulx(xval_t a, xval_t b);
		xval_t r;
		logic [21:0] pm;
		r.neg = a.neg ^ b.neg;
		r.mag = '0;
		r.exp = '0;
		pm = a.mag[10:0] * b.mag[10:0];
		if (a.cls == CLS_NAN || b.cls == CLS_NAN) begin
			r.cls = CLS_NAN;
		end else if (a.cls == CLS_INF || b.cls == CLS_INF) begin
			r.cls = (a.cls == CLS_ZERO || b.cls == CLS_ZERO) ? CLS_NAN : CLS_INF;
		end else if (a.cls == CLS_ZERO || b.cls == CLS_ZERO) begin
			r.cls = CLS_ZERO;
		end else begin
			r.cls = CLS_FIN;
			r.mag = {6'd0, pm};
			r.exp = a.exp + b.exp;
		end
		return r;
	endfunction

	// align to bit 26, jam shifted-out bits into bit 0
	function automatic xval_t addx(xval_t a, xval_t b);
		xval_t r;
		logic [27:0] am, bm, bigm, smlm, sm;
		logic bign, smln;
		int da, db, ae, be, bige, d;
		r.cls = CLS_FIN;
		r.neg = 1'b0;
		r.mag = '0;
		r.exp = '0;
		da = 26 - msb28(a.mag);
		db = 26 - msb28(b.mag);
		am = a.mag << da;
		bm = b.mag << db;
		ae = int'(a.exp) - da;
		be = int'(b.exp) - db;
		if (ae >= be) begin
			bigm = am; bign = a.neg; bige = ae; smlm = bm; smln = b.neg; d = ae - be;
		end else begin
			bigm = bm; bign = b.neg; bige = be; smlm = am; smln = a.neg; d = be - ae;
		end
		if (d >= 27) sm = 28'd1;
		else sm = (smlm >> d) | 28'(((smlm >> d) << d) != smlm);
		if (a.cls == CLS_NAN || b.cls == CLS_NAN) begin
			r.cls = CLS_NAN;
		end else if (a.cls == CLS_INF && b.cls == CLS_INF) begin
			r.cls = (a.neg == b.neg) ? CLS_INF : CLS_NAN;
			r.neg = a.neg;
		end else if (a.cls == CLS_INF) begin
			r = a;
		end else if (b.cls == CLS_INF) begin
			r = b;
		end else if (a.cls == CLS_ZERO && b.cls == CLS_ZERO) begin
			r.cls = CLS_ZERO;
			r.neg = a.neg & b.neg;
		end else if (a.cls == CLS_ZERO) begin
			r = b;
		end else if (b.cls == CLS_ZERO) begin
			r = a;
		end else begin
			r.exp = 10'(bige);
			if (bign == smln) begin
				r.mag = bigm + sm;
				r.neg = bign;
			end else if (bigm >= sm) begin
				r.mag = bigm - sm;
				r.neg = bign;
			end else begin
				r.mag = sm - bigm;
				r.neg = smln;
			end
			if (r.mag == 28'd0) begin
				r.cls = CLS_ZERO;
				r.neg = 1'b0;
			end
		end
		return r;
	endfunction

	// round to nearest even and pack, gradual underflow, overflow to infinity
	function automatic logic [31:0] enc(xval_t x, int mb, int qmin, int emask, int sbit);
		logic [31:0] sgn, inf, n, bits;
		logic [28:0] keep, rem, half;
		int p, q, s;
		sgn = {31'd0, x.neg} << sbit;
		inf = 32'(emask) << mb;
		p = msb28(x.mag);
		q = p + int'(x.exp) - mb;
		if (q < qmin) q = qmin;
		s = q - int'(x.exp);
		n = '0;
		if (s <= 0) begin
			n = 32'(x.mag) << (-s);
		end else if (s < 29) begin
			keep = {1'b0, x.mag} >> s;
			rem  = {1'b0, x.mag} & ((29'd1 << s) - 29'd1);
			half = 29'd1 << (s - 1);
			if (rem > half || (rem == half && keep[0])) keep = keep + 29'd1;
			n = 32'(keep);
		end
		bits = (32'(q - qmin) << mb) + n;
		if (bits >= inf) bits = inf;
		if (x.cls == CLS_NAN) return inf | (32'd1 << (mb - 1));
		if (x.cls == CLS_INF) return sgn | inf;
		if (x.cls == CLS_ZERO || x.mag == 28'd0) return sgn;
		if (q > qmin + emask - 2) return sgn | inf;
		return sgn | bits;
	endfunction

	function automatic logic [15:0] enc16(xval_t x);
		logic [31:0] w;
		w = enc(x, 10, -24, 31, 15);
		return w[15:0];
	endfunction

	function automatic logic [31:0] enc32(xval_t x);
		return enc(x, 23, -149, 255, 31);
	endfunction

endpackage

@@ rtl/nf4_lane.sv @@
// One column lane: dequantize, fused multiply-add into four fp16 partials,
// tile reduction and fp32 running sum. Depends on nf4_pkg.
module nf4_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  nf4_pkg::lane_ctl_t ctl,
	input  logic [3:0]        code,
	input  logic [15:0]       scale,
	input  logic [15:0]       act16,
	output logic [31:0]       run_sum
);
	import nf4_pkg::*;

	logic [15:0] acc_q [4];
	logic [31:0] run_q;
	xval_t       prod_q;
	xval_t       sum_q;
	logic [15:0] w_q;
	logic [15:0] s01_q;
	logic [15:0] s23_q;

	logic [15:0] sum16;
	assign sum16 = enc16(sum_q);
	assign run_sum = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			run_q <= '0;
		end else begin
			case (ctl.st)
				S_WB: acc_q[ctl.slot] <= sum16;
				S_F7: begin
					for (int i = 0; i < 4; i++) acc_q[i] <= '0;
					run_q <= enc32(sum_q);
				end
				S_OUT: if (ctl.clr_run) run_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.st)
			S_ACT: prod_q <= mulx(tab_val(code), dec16(scale));
			S_W:   w_q <= enc16(prod_q);
			S_MUL: prod_q <= mulx(dec16(w_q), dec16(act16));
			S_ADD: sum_q <= addx(dec16(acc_q[ctl.slot]), prod_q);
			S_F1:  sum_q <= addx(dec16(acc_q[0]), dec16(acc_q[1]));
			S_F2: begin
				s01_q <= sum16;
				sum_q <= addx(dec16(acc_q[2]), dec16(acc_q[3]));
			end
			S_F3:  s23_q <= sum16;
			S_F4:  sum_q <= addx(dec16(s01_q), dec16(s23_q));
			S_F5:  w_q <= sum16;
			S_F6:  sum_q <= addx(dec32(run_q), dec16(w_q));
			default: ;
		endcase
	end

endmodule

@@ rtl/nf4_dequant_gemv_fp16.sv @@
// NF4 dequantizing GEMV column block, top level: row sequencer, eight lanes
// and the column output merge. Depends on nf4_pkg and nf4_lane.
//
// Each input transfer carries one matrix row for an 8-column block. After
// a row's transfer the block steps through scale multiply, fp16 rounding,
// activation multiply, accumulator add and write-back before it is ready
// again, all done by one fp16 multiply/add path per lane working on the
// eight columns in parallel. When a tile of ROWS_PER_TILE rows fills, or
// on the row flagged last_row, a flush sequence reduces the four partial
// accumulators as (a0+a1)+(a2+a3) and adds the result into the fp32 running
// sum. On the last row the block then offers 8 result transfers, columns
// 0 to 7, one per cycle while out_ready is high, and accepts no row until
// column 7 has gone; the running sums then clear for the next vector.
module nf4_dequant_gemv_fp16 #(
	parameter int ROWS_PER_TILE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] activation,
	input  logic [31:0] weight_codes,
	input  logic [63:0] scales_low,
	input  logic [63:0] scales_high,
	input  logic        last_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [nf4_pkg::COL_W-1:0] column_index,
	output logic [31:0] column_sum,
	output logic        last_column
);
	import nf4_pkg::*;

	localparam int ROW_W = $clog2(ROWS_PER_TILE + 1);

	nf4_state_t         state_q, state_d;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               last_q;
	logic [31:0]        act_q;
	logic [31:0]        codes_q;
	logic [127:0]       scl_q;
	logic [15:0]        act16_q;
	logic [31:0]        run_sum [COLUMNS];
	lane_ctl_t          ctl;
	logic               in_xfer, out_xfer, tile_done;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid & in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_xfer  = out_valid & out_ready;
	// tile ends when this row fills it or the vector ends here
	assign tile_done = (row_q + ROW_W'(1) == ROW_W'(ROWS_PER_TILE)) || last_q;

	assign column_index = col_q;
	assign column_sum   = run_sum[col_q];
	assign last_column  = (col_q == COL_W'(COLUMNS - 1));

	assign ctl.st      = state_q;
	assign ctl.slot    = row_q[1:0];
	assign ctl.clr_run = out_xfer && last_column;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_xfer) state_d = S_ACT;
			S_ACT:  state_d = S_W;
			S_W:    state_d = S_MUL;
			S_MUL:  state_d = S_ADD;
			S_ADD:  state_d = S_WB;
			S_WB:   state_d = tile_done ? S_F1 : S_IDLE;
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_F3;
			S_F3:   state_d = S_F4;
			S_F4:   state_d = S_F5;
			S_F5:   state_d = S_F6;
			S_F6:   state_d = S_F7;
			S_F7:   state_d = last_q ? S_OUT : S_IDLE;
			S_OUT:  if (out_xfer && last_column) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			// advance the row count; clear it once the tile is folded in
			if (state_q == S_WB && !tile_done) row_q <= row_q + ROW_W'(1);
			if (state_q == S_F7) row_q <= '0;
			if (out_xfer) col_q <= last_column ? '0 : col_q + COL_W'(1);
		end
	end

	// hold the row payload for the duration of its work
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q   <= activation;
			codes_q <= weight_codes;
			scl_q   <= {scales_high, scales_low};
			last_q  <= last_row;
		end
		// round the fp32 activation to fp16 once per row
		if (state_q == S_ACT) act16_q <= enc16(dec32(act_q));
	end

	for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
		nf4_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.code    (codes_q[4*c +: 4]),
			.scale   (scl_q[16*c +: 16]),
			.act16   (act16_q),
			.run_sum (run_sum[c])
		);
	end

	a_out_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_q)
		else $error("result offered for a row that was not last");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while results pending");
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_F7 |=> row_q == '0)
		else $error("row count not cleared after tile flush");
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last_column |=> state_q == S_IDLE && col_q == '0)
		else $error("output run did not close on column 7");

endmodule

@@ sim/nf4_gemv_checker.sv @@
// Scoreboard for the NF4 dequantizing GEMV column block: watches both channels,
// predicts the eight fp32 column sums per vector, and compares every transfer.
// Depends on nf4_pkg for COL_W and the value classes.
module nf4_gemv_checker #(
	parameter int ROWS_PER_TILE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] activation,
	input  logic [31:0] weight_codes,
	input  logic [63:0] scales_low,
	input  logic [63:0] scales_high,
	input  logic        last_row,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [nf4_pkg::COL_W-1:0] column_index,
	input  logic [31:0] column_sum,
	input  logic        last_column,
	output int          fail_count,
	output int          pending_sums
);
	timeunit 1ns;
	timeprecision 1ps;
	import nf4_pkg::*;

	typedef struct {
		logic [1:0] cls;
		bit         neg;
		longint unsigned mag;
		int         ex;
	} fval_t;

	typedef struct {
		logic [nf4_pkg::COL_W-1:0] col;
		logic [31:0] sum;
		logic        last;
	} col_sum_t;

	int lut [16] = '{-127, -88, -67, -50, -36, -23, -12, 0, 10, 20, 31, 43, 56, 71, 92, 127};

	logic [15:0] acc [4][8];
	logic [31:0] run_sum [8];
	int          rows_seen;
	col_sum_t    sum_q [$];

	function automatic int top_bit(longint unsigned v);
		int p;
		p = 0;
		while (v > 1) begin
			v = v >> 1;
			p++;
		end
		return p;
	endfunction

	// mb: fraction bits, qmin: lowest quantum exponent, em: exponent mask
	function automatic fval_t unpack(logic [31:0] b, int mb, int qmin, int em);
		fval_t x;
		int e;
		longint unsigned fr;
		e = int'((b >> mb) & em);
		fr = b & ((32'd1 << mb) - 1);
		x.neg = b[mb == 10 ? 15 : 31];
		x.mag = 0;
		x.ex = 0;
		if (e == em) x.cls = fr != 0 ? CLS_NAN : CLS_INF;
		else if (e == 0) begin
			x.cls = fr != 0 ? CLS_FIN : CLS_ZERO;
			x.mag = fr;
			x.ex = qmin;
		end else begin
			x.cls = CLS_FIN;
			x.mag = fr | (64'd1 << mb);
			x.ex = qmin + e - 1;
		end
		return x;
	endfunction

	function automatic logic [31:0] pack(fval_t x, int mb, int qmin, int em);
		logic [31:0] sgn, inf, bits;
		longint unsigned n, keep, rem, half;
		int q, s;
		sgn = 32'(x.neg) << (mb == 10 ? 15 : 31);
		inf = 32'(em) << mb;
		if (x.cls == CLS_NAN) return inf | (32'd1 << (mb - 1));
		if (x.cls == CLS_INF) return sgn | inf;
		if (x.cls == CLS_ZERO || x.mag == 0) return sgn;
		q = top_bit(x.mag) + x.ex - mb;
		if (q < qmin) q = qmin;
		if (q > qmin + em - 2) return sgn | inf;
		s = q - x.ex;
		if (s <= 0) n = x.mag << (-s);
		else if (s >= 64) n = (s == 64 && x.mag > (64'd1 << 63)) ? 1 : 0;
		else begin
			keep = x.mag >> s;
			rem = x.mag & ((64'd1 << s) - 1);
			half = 64'd1 << (s - 1);
			if (rem > half || (rem == half && keep[0])) keep++;
			n = keep;
		end
		bits = (32'(q - qmin) << mb) + 32'(n);
		if (bits >= inf) bits = inf;
		return sgn | bits;
	endfunction

	function automatic fval_t h16(logic [15:0] b);
		return unpack({16'd0, b}, 10, -24, 31);
	endfunction

	function automatic logic [15:0] r16(fval_t x);
		logic [31:0] w;
		w = pack(x, 10, -24, 31);
		return w[15:0];
	endfunction

	function automatic fval_t times(fval_t a, fval_t b);
		fval_t r;
		r.neg = a.neg ^ b.neg;
		r.mag = 0;
		r.ex = 0;
		if (a.cls == CLS_NAN || b.cls == CLS_NAN) r.cls = CLS_NAN;
		else if (a.cls == CLS_INF || b.cls == CLS_INF)
			r.cls = (a.cls == CLS_ZERO || b.cls == CLS_ZERO) ? CLS_NAN : CLS_INF;
		else if (a.cls == CLS_ZERO || b.cls == CLS_ZERO) r.cls = CLS_ZERO;
		else begin
			r.cls = CLS_FIN;
			r.mag = a.mag * b.mag;
			r.ex = a.ex + b.ex;
		end
		return r;
	endfunction

	// exact-then-sticky add: both operands left-aligned to bit 61
	function automatic fval_t plus(fval_t a, fval_t b);
		fval_t r, hi, lo;
		longint unsigned sm;
		int d;
		r.cls = CLS_FIN;
		r.mag = 0;
		r.ex = 0;
		r.neg = 0;
		if (a.cls == CLS_NAN || b.cls == CLS_NAN) begin
			r.cls = CLS_NAN;
			return r;
		end
		if (a.cls == CLS_INF && b.cls == CLS_INF) begin
			r.cls = a.neg == b.neg ? CLS_INF : CLS_NAN;
			r.neg = a.neg;
			return r;
		end
		if (a.cls == CLS_INF) return a;
		if (b.cls == CLS_INF) return b;
		if (a.cls == CLS_ZERO && b.cls == CLS_ZERO) begin
			r.cls = CLS_ZERO;
			r.neg = a.neg & b.neg;
			return r;
		end
		if (a.cls == CLS_ZERO) return b;
		if (b.cls == CLS_ZERO) return a;
		d = 61 - top_bit(a.mag);
		a.mag = a.mag << d;
		a.ex -= d;
		d = 61 - top_bit(b.mag);
		b.mag = b.mag << d;
		b.ex -= d;
		if (a.ex >= b.ex) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		d = hi.ex - lo.ex;
		if (d >= 62) sm = 1;
		else if (d == 0) sm = lo.mag;
		else sm = (lo.mag >> d) | 64'((lo.mag & ((64'd1 << d) - 1)) != 0);
		r.ex = hi.ex;
		if (hi.neg == lo.neg) begin
			r.mag = hi.mag + sm;
			r.neg = hi.neg;
		end else if (hi.mag >= sm) begin
			r.mag = hi.mag - sm;
			r.neg = hi.neg;
		end else begin
			r.mag = sm - hi.mag;
			r.neg = lo.neg;
		end
		if (r.mag == 0) begin
			r.cls = CLS_ZERO;
			r.neg = 0;
		end
		return r;
	endfunction

	function automatic logic [15:0] hsum(logic [15:0] x, logic [15:0] y);
		return r16(plus(h16(x), h16(y)));
	endfunction

	task automatic reduce_tile();
		logic [15:0] s01, s23;
		for (int c = 0; c < 8; c++) begin
			s01 = hsum(acc[0][c], acc[1][c]);
			s23 = hsum(acc[2][c], acc[3][c]);
			run_sum[c] = pack(plus(unpack(run_sum[c], 23, -149, 255), h16(hsum(s01, s23))),
				23, -149, 255);
			for (int k = 0; k < 4; k++) acc[k][c] = '0;
		end
		rows_seen = 0;
	endtask

	task automatic predict_row();
		fval_t act, tv, w;
		logic [15:0] sc;
		int t, k;
		act = h16(r16(unpack(activation, 23, -149, 255)));
		k = rows_seen % 4;
		for (int c = 0; c < 8; c++) begin
			t = lut[weight_codes[4*c +: 4]];
			sc = c < 4 ? scales_low[16*c +: 16] : scales_high[16*(c-4) +: 16];
			tv.cls = t != 0 ? CLS_FIN : CLS_ZERO;
			tv.neg = t < 0;
			tv.mag = t < 0 ? -t : t;
			tv.ex = 0;
			w = h16(r16(times(tv, h16(sc))));
			acc[k][c] = r16(plus(h16(acc[k][c]), times(w, act)));
		end
		rows_seen++;
		if (rows_seen >= ROWS_PER_TILE || last_row) reduce_tile();
		if (last_row) begin
			for (int c = 0; c < 8; c++) begin
				sum_q.push_back('{col: 3'(c), sum: run_sum[c], last: c == 7});
				run_sum[c] = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 8; c++) begin
				run_sum[c] = '0;
				for (int k = 0; k < 4; k++) acc[k][c] = '0;
			end
			rows_seen = 0;
			fail_count = 0;
			sum_q.delete();
			pending_sums = 0;
		end else begin
			// check outputs first: a row accepted this edge cannot have results yet
			if (out_valid && out_ready) begin
				if (sum_q.size() == 0) begin
					$error("column sum transfer with nothing expected: col %0d sum %h",
						column_index, column_sum);
					fail_count++;
				end else begin
					col_sum_t e;
					e = sum_q.pop_front();
					if (column_index !== e.col) begin
						$error("column_index expected %0d got %0d", e.col, column_index);
						fail_count++;
					end
					if (column_sum !== e.sum) begin
						$error("column_sum expected %h got %h", e.sum, column_sum);
						fail_count++;
					end
					if (last_column !== e.last) begin
						$error("last_column expected %0b got %0b", e.last, last_column);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) predict_row();
			pending_sums = sum_q.size();
		end
	end
endmodule

@@ sim/nf4_dequant_gemv_fp16_tb.sv @@
// Testbench top for nf4_dequant_gemv_fp16: drives rows with random gaps and
// output stalls, instantiates the block and nf4_gemv_checker, gives the verdict.
// Depends on nf4_pkg, the block RTL and sim/nf4_gemv_checker.sv.
module nf4_dequant_gemv_fp16_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] activation = '0;
	logic [31:0] weight_codes = '0;
	logic [63:0] scales_low = '0;
	logic [63:0] scales_high = '0;
	logic        last_row = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [nf4_pkg::COL_W-1:0] column_index;
	logic [31:0] column_sum;
	logic        last_column;
	int          fail_count;
	int          pending_sums;
	bit          long_hold = 1'b0;	// ask the receiver for one long stall
	bit          stim_done = 1'b0;

	always #5 clk = ~clk;

	nf4_dequant_gemv_fp16 #(.ROWS_PER_TILE(ROWS)) DUT (.*);

	nf4_gemv_checker #(.ROWS_PER_TILE(ROWS)) u_checker (.*);

	// Pick a value that exercises fp16 activation rounding: mostly normal-range
	// fp32, sometimes zeros, infinities, NaN, subnormals and overflow values.
	function automatic logic [31:0] pick_act();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 15))
			0: return {r[31], 31'd0};
			1: return {r[31], 8'hff, 23'd0};
			2: return {r[31], 8'hff, r[22:0] | 23'd1};
			3: return r;
			4: return {r[31], 8'(8'd100 + r[25:23]), r[22:0]};	// fp16 subnormal range
			5: return {r[31], 8'(8'd140 + r[24:23]), r[22:0]};	// near fp16 overflow
			default: return {r[31], 8'(8'd120 + r[26:23] % 14), r[22:0]};
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		logic [15:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 19))
			0: return {r[15], 15'd0};
			1: return {r[15], 5'h1f, 10'd0};
			2: return {r[15], 5'h1f, r[9:0] | 10'd1};
			3: return r;
			4: return {r[15], 5'd0, r[9:0]};
			default: return {r[15], 5'(5'd8 + r[13:10] % 8), r[9:0]};
		endcase
	endfunction

	// Present one row at the falling edge and hold it until the transfer.
	// Valid stays high after the transfer; drop it only when a gap follows.
	task automatic send_row(input logic [31:0] a, input logic [31:0] w,
			input logic [63:0] lo, input logic [63:0] hi, input bit last);
		int gap;
		gap = long_hold ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		activation <= a;
		weight_codes <= w;
		scales_low <= lo;
		scales_high <= hi;
		last_row <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_row(input bit last);
		logic [63:0] lo, hi;
		for (int c = 0; c < 4; c++) begin
			lo[16*c +: 16] = pick_scale();
			hi[16*c +: 16] = pick_scale();
		end
		send_row(pick_act(), $urandom, lo, hi, last);
	endtask

	// Receiver: random stall per result, plus one long hold when asked.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (150) @(negedge clk);
				long_hold = 1'b0;
			end
			wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (wait_n != 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int n, len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: two-row vector with extremes and every table entry.
		send_row(32'h3f80_0000, 32'hfedc_ba98, 64'h3c00_3c00_3c00_3c00,
			64'h3c00_3c00_3c00_3c00, 1'b0);
		send_row(32'hbf80_0000, 32'h7654_3210, 64'h3c00_3c00_3c00_3c00,
			64'h3c00_3c00_3c00_3c00, 1'b1);
		// Overflow to infinity, inf*0 and inf-inf produce NaN, signed zeros.
		send_row(32'h4780_0000, 32'hffff_ffff, 64'h7bff_7bff_7bff_7bff,
			64'h7c00_7c00_0000_8000, 1'b0);
		send_row(32'h4780_0000, 32'h0000_0000, 64'h7bff_7bff_7bff_7bff,
			64'h7c00_fc00_7e01_8001, 1'b1);
		send_row(32'h8000_0000, 32'h7777_7777, 64'h8000_0000_8000_0000,
			64'hffff_0000_ffff_ffff, 1'b1);
		send_row(32'hffff_ffff, 32'h8888_8888, 64'h0001_8001_0001_03ff,
			64'hffff_ffff_ffff_ffff, 1'b1);
		send_row(32'h0000_0001, 32'h1234_5678, 64'h0000_0000_0000_0000,
			64'h0000_0000_0000_0000, 1'b1);
		// Full tile reduced on the last row, then a vector one past a tile.
		for (int i = 0; i < ROWS; i++) send_random_row(i == ROWS - 1);
		in_valid <= 1'b0;
		while (pending_sums != 0) @(negedge clk);	// sender pauses until drained
		for (int i = 0; i <= ROWS; i++) send_random_row(i == ROWS);

		// Long receiver stall while rows keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 6; i++) send_random_row(i == 2 || i == 5);

		// Random vectors, mostly short, some crossing tile boundaries.
		n = 0;
		while (n < 110) begin
			len = $urandom_range(0, 5) == 0 ? $urandom_range(ROWS - 2, ROWS + 6) :
				$urandom_range(1, 6);
			for (int i = 0; i < len; i++) send_random_row(i == len - 1);
			n += len;
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending_sums != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ files.f @@
rtl/nf4_pkg.sv
rtl/nf4_lane.sv
rtl/nf4_dequant_gemv_fp16.sv
sim/nf4_gemv_checker.sv
sim/nf4_dequant_gemv_fp16_tb.sv
